@@ src/mlb_pkg.sv @@
// Shared types and constants for the multichannel lowpass biquad.
package mlb_pkg;

    localparam int CHANNEL_BITS   = 4;
    localparam int CHANNEL_SPAN   = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int A0_BITS        = 30;
    localparam int B_BITS         = 31;
    localparam int ACC_BITS       = 64;
    localparam int COEF_EXT_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_A0 = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_B1 = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_B2 = 2'd2;

    localparam logic [A0_BITS-1:0]       A0_RESET = 30'd2102432;
    localparam logic signed [B_BITS-1:0] B1_RESET = -31'sd974603242;
    localparam logic signed [B_BITS-1:0] B2_RESET = 31'sd446145097;

    typedef struct packed {
        logic                    rd_en;
        logic [CHANNEL_BITS-1:0] rd_ch;
        logic                    wr_en;
        logic [CHANNEL_BITS-1:0] wr_ch;
    } store_ctl_t;

endpackage

@@ src/mlb_hist_store.sv @@
// Per-channel filter history memory with reset valid bits and write-to-read bypass.
module mlb_hist_store #(
    parameter int NUM_CHANNELS = 16,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mlb_pkg::store_ctl_t      ctl,
    input  logic [4*SAMPLE_BITS-1:0] wr_data,
    output logic [4*SAMPLE_BITS-1:0] rd_data
);

    // Only the channels that the channel field can name need storage.
    localparam int DEPTH = (NUM_CHANNELS < mlb_pkg::CHANNEL_SPAN) ?
                           NUM_CHANNELS : mlb_pkg::CHANNEL_SPAN;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int HW    = 4 * SAMPLE_BITS;

    logic [HW-1:0]    mem [DEPTH];
    logic [HW-1:0]    mem_rd_reg;
    logic [HW-1:0]    fwd_data_reg;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic             rd_vld_reg;
    logic             rd_vld_next;
    logic             bypass_reg;
    logic             bypass_next;
    logic             wr_ok;
    logic             rd_ok;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;

    assign wr_idx = ctl.wr_ch[IDX_W-1:0];
    assign rd_idx = ctl.rd_ch[IDX_W-1:0];
    assign wr_ok  = ctl.wr_en && (32'(ctl.wr_ch) < NUM_CHANNELS);
    assign rd_ok  = 32'(ctl.rd_ch) < NUM_CHANNELS;

    always_comb begin
        vld_next    = vld_reg;
        rd_vld_next = rd_vld_reg;
        bypass_next = bypass_reg;
        if (wr_ok) begin
            vld_next[wr_idx] = 1'b1;
        end
        if (ctl.rd_en) begin
            rd_vld_next = rd_ok && vld_reg[rd_idx];
            // A write to the same channel on the same edge is not yet in the array.
            bypass_next = rd_ok && wr_ok && (ctl.wr_ch == ctl.rd_ch);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            bypass_reg <= 1'b0;
        end else begin
            vld_reg    <= vld_next;
            rd_vld_reg <= rd_vld_next;
            bypass_reg <= bypass_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wr_idx] <= wr_data;
        end
        if (ctl.rd_en) begin
            mem_rd_reg   <= mem[rd_idx];
            fwd_data_reg <= wr_data;
        end
    end

    always_comb begin
        if (bypass_reg) begin
            rd_data = fwd_data_reg;
        end else if (rd_vld_reg) begin
            rd_data = mem_rd_reg;
        end else begin
            rd_data = '0;
        end
    end

endmodule

@@ src/mlb_datapath.sv @@
// Biquad arithmetic: five products, accumulate, round and saturate.
module mlb_datapath #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 29
) (
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic        [4*SAMPLE_BITS-1:0]       hist,
    input  logic        [mlb_pkg::A0_BITS-1:0]    coef_a0,
    input  logic signed [mlb_pkg::B_BITS-1:0]     coef_b1,
    input  logic signed [mlb_pkg::B_BITS-1:0]     coef_b2,
    output logic signed [SAMPLE_BITS-1:0]         result
);

    localparam int CW        = mlb_pkg::COEF_EXT_BITS;
    localparam int AW        = mlb_pkg::ACC_BITS;
    localparam int PROD_BITS = SAMPLE_BITS + CW;

    localparam logic signed [AW-1:0] ROUND_HALF = 64'sd1 <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] MAX_VAL    = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [AW-1:0] MIN_VAL    = -MAX_VAL - 64'sd1;

    logic signed [CW-1:0]          a0_s;
    logic signed [CW-1:0]          a1_s;
    logic signed [CW-1:0]          b1_s;
    logic signed [CW-1:0]          b2_s;
    logic signed [SAMPLE_BITS-1:0] x1;
    logic signed [SAMPLE_BITS-1:0] x2;
    logic signed [SAMPLE_BITS-1:0] y1;
    logic signed [SAMPLE_BITS-1:0] y2;
    logic signed [PROD_BITS-1:0]   p_x0;
    logic signed [PROD_BITS-1:0]   p_x1;
    logic signed [PROD_BITS-1:0]   p_x2;
    logic signed [PROD_BITS-1:0]   p_y1;
    logic signed [PROD_BITS-1:0]   p_y2;
    logic signed [AW-1:0]          acc;
    logic signed [AW-1:0]          scaled;

    assign a0_s = $signed({2'b00, coef_a0});
    assign a1_s = $signed({1'b0, coef_a0, 1'b0});
    assign b1_s = CW'(coef_b1);
    assign b2_s = CW'(coef_b2);

    assign x1 = $signed(hist[SAMPLE_BITS-1:0]);
    assign x2 = $signed(hist[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign y1 = $signed(hist[3*SAMPLE_BITS-1:2*SAMPLE_BITS]);
    assign y2 = $signed(hist[4*SAMPLE_BITS-1:3*SAMPLE_BITS]);

    assign p_x0 = a0_s * sample;
    assign p_x1 = a1_s * x1;
    assign p_x2 = a0_s * x2;
    assign p_y1 = b1_s * y1;
    assign p_y2 = b2_s * y2;

    // The accumulator wraps at its full width.
    assign acc = AW'(p_x0) + AW'(p_x1) + AW'(p_x2) - AW'(p_y1) - AW'(p_y2) + ROUND_HALF;
    assign scaled = acc >>> COEF_FRAC_BITS;

    always_comb begin
        if (scaled > MAX_VAL) begin
            result = MAX_VAL[SAMPLE_BITS-1:0];
        end else if (scaled < MIN_VAL) begin
            result = MIN_VAL[SAMPLE_BITS-1:0];
        end else begin
            result = scaled[SAMPLE_BITS-1:0];
        end
    end

endmodule

@@ src/multichannel_lowpass_biquad_top.sv @@
// Top level of the multichannel second-order lowpass biquad filter.
//
// Input stream: s_tdata carries one signed sample, s_tuser the channel whose
// history the sample runs through. Output stream: m_tdata carries the filtered
// sample, rounded and saturated to SAMPLE_BITS, m_tuser the same channel.
// Coefficients must be written through the cfg_* channel while the filter is
// idle, not enforced here; cfg_index 0 is a0, 1 is b1, 2 is b2, 3 is dropped.
//
// Throughput is one sample per clock cycle while m_tready is high. The whole
// filter equation sits between the input stage register and the output
// register, so a sample for the channel just processed can follow in the next
// cycle: its history is bypassed from the write port of the history memory.
// A sample waits in the input stage register, then in the output register.
//
// Reset clears the coefficient registers to their defaults, empties both
// pipeline registers and marks the history of every channel as zero at once.
// When the receiver holds m_tready low, the result waits in the output
// register, the next sample waits in the input stage, and s_tready falls
// only while both are occupied.
module multichannel_lowpass_biquad_top #(
    parameter int NUM_CHANNELS   = 16,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 29
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Input stream.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,  // sample_in
    input  logic [mlb_pkg::CHANNEL_BITS-1:0]      s_tuser,  // channel
    // Output stream.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,  // sample_out
    output logic [mlb_pkg::CHANNEL_BITS-1:0]      m_tuser,  // out_channel
    // Coefficient write channel.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mlb_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [mlb_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    // Coefficients.
    logic        [mlb_pkg::A0_BITS-1:0] coef_a0_reg;
    logic signed [mlb_pkg::B_BITS-1:0]  coef_b1_reg;
    logic signed [mlb_pkg::B_BITS-1:0]  coef_b2_reg;

    // Input stage and output register.
    logic                                st_valid_reg;
    logic                                st_valid_next;
    logic signed [SAMPLE_BITS-1:0]       st_sample_reg;
    logic [mlb_pkg::CHANNEL_BITS-1:0]    st_channel_reg;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [SAMPLE_BITS-1:0]       out_sample_reg;
    logic [mlb_pkg::CHANNEL_BITS-1:0]    out_channel_reg;

    logic                                accept;
    logic                                advance;
    logic                                cfg_write;
    mlb_pkg::store_ctl_t                 store_ctl;
    logic [4*SAMPLE_BITS-1:0]            hist;
    logic [4*SAMPLE_BITS-1:0]            hist_wr;
    logic signed [SAMPLE_BITS-1:0]       result;

    // The stage moves forward whenever the output register is free or drains.
    assign advance  = st_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !st_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_a0_reg <= mlb_pkg::A0_RESET;
            coef_b1_reg <= mlb_pkg::B1_RESET;
            coef_b2_reg <= mlb_pkg::B2_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                mlb_pkg::CFG_COEF_A0: coef_a0_reg <= cfg_data[mlb_pkg::A0_BITS-1:0];
                mlb_pkg::CFG_COEF_B1: coef_b1_reg <= $signed(cfg_data[mlb_pkg::B_BITS-1:0]);
                mlb_pkg::CFG_COEF_B2: coef_b2_reg <= $signed(cfg_data[mlb_pkg::B_BITS-1:0]);
                default: ;
            endcase
        end
    end

    // History is read as a sample enters the stage and written back as it leaves.
    assign store_ctl.rd_en = accept;
    assign store_ctl.rd_ch = s_tuser;
    assign store_ctl.wr_en = advance;
    assign store_ctl.wr_ch = st_channel_reg;

    // New history: y2 <- y1, y1 <- y, x2 <- x1, x1 <- x.
    assign hist_wr = {hist[3*SAMPLE_BITS-1:2*SAMPLE_BITS], result,
                      hist[SAMPLE_BITS-1:0], st_sample_reg};

    mlb_hist_store #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (store_ctl),
        .wr_data (hist_wr),
        .rd_data (hist)
    );

    mlb_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .sample  (st_sample_reg),
        .hist    (hist),
        .coef_a0 (coef_a0_reg),
        .coef_b1 (coef_b1_reg),
        .coef_b2 (coef_b2_reg),
        .result  (result)
    );

    always_comb begin
        st_valid_next  = st_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
            st_valid_next  = 1'b0;
        end
        if (accept) begin
            st_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st_valid_reg  <= st_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_sample_reg  <= $signed(s_tdata[SAMPLE_BITS-1:0]);
            st_channel_reg <= s_tuser;
        end
        if (advance) begin
            out_sample_reg  <= result;
            out_channel_reg <= st_channel_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_BITS'($unsigned(out_sample_reg));
    assign m_tuser  = out_channel_reg;

endmodule

@@ src/mlb_checker.sv @@
// Port-level assertions for the multichannel lowpass biquad, bound to the top level.
module mlb_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,
    input logic [mlb_pkg::CHANNEL_BITS-1:0]   m_tuser
);

    // A stalled result keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or dropped");

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // The input side only backs up when the output side is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output is free");

    // An input transfer is followed by a valid result on offer at the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("result missing after input transfer");

endmodule

bind multichannel_lowpass_biquad_top mlb_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mlb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
